### hw/rtl/adp_pkg.sv
`default_nettype none

package adp_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned RegCnt  = 16;
  localparam int unsigned RegIdxW = 4;
  localparam int unsigned Op2W    = 12;

  // item mode
  typedef enum logic [1:0] {
    MODE_EXEC = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_READ = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // supported data-processing opcodes
  typedef enum logic [3:0] {
    OPC_AND = 4'd0,
    OPC_EOR = 4'd1,
    OPC_SUB = 4'd2,
    OPC_RSB = 4'd3,
    OPC_ADD = 4'd4,
    OPC_TST = 4'd8,
    OPC_TEQ = 4'd9,
    OPC_CMP = 4'd10,
    OPC_ORR = 4'd12,
    OPC_MOV = 4'd13
  } opcode_t;

  // shift types in operand2
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // flag bit positions
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagC = 0;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] rn;
    logic [RegIdxW-1:0] rm;
    logic [RegIdxW-1:0] rs;
  } rf_rd_t;

  typedef struct packed {
    logic               en;
    logic [RegIdxW-1:0] addr;
    logic [DataW-1:0]   data;
  } rf_wr_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
  } shift_res_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             carry;
    logic             wr;
    logic             ok;
  } alu_res_t;

  // rotate right by 0..31
  function automatic logic [DataW-1:0] ror32(input logic [DataW-1:0] x,
                                             input logic [4:0]       r);
    logic [2*DataW-1:0] d;
    d = {x, x} >> r;
    return d[DataW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/adp_if.sv
`default_nettype none

// instruction item channel
interface adp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  opcode;
  logic        imm_flag;
  logic        set_flags;
  logic [3:0]  first_reg;
  logic [3:0]  dest_reg;
  logic [11:0] op2_field;
  logic [31:0] load_value;

  modport source (
    output valid, mode, opcode, imm_flag, set_flags, first_reg, dest_reg,
           op2_field, load_value,
    input  ready
  );
  modport sink (
    input  valid, mode, opcode, imm_flag, set_flags, first_reg, dest_reg,
           op2_field, load_value,
    output ready
  );
endinterface

// result item channel
interface adp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        wrote;
  logic [3:0]  written_reg;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        unsupported;

  modport source (
    output valid, value, wrote, written_reg, flag_n, flag_z, flag_c, unsupported,
    input  ready
  );
  modport sink (
    input  valid, value, wrote, written_reg, flag_n, flag_z, flag_c, unsupported,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/arm_data_processing_alu_top.sv
// Channel | Dir | Payload
// in_ch   | in  | mode, opcode, imm_flag, set_flags, first_reg, dest_reg,
//         |     | op2_field, load_value
// out_ch  | out | value, wrote, written_reg, flag_n, flag_z, flag_c, unsupported
//
// One item per clock sustained while out_ch is ready; out_ch.valid rises once the item
// has passed the execute stage into the output register: register file read at the
// accepting edge, then shift, ALU and write-back into the output register. Same-edge
// write/read of a register is bypassed.
// Reset clears the register valid bits, the flags and the stage valids; no
// clearing pass is needed. A stalled output holds the execute stage, and in_ch
// stops taking items only while that stage is full and cannot move.
`default_nettype none

module arm_data_processing_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  adp_in_if.sink      in_ch,
  adp_out_if.source   out_ch
);

  logic in_fire;
  logic s1_adv;

  // execute stage item
  logic                         s1_valid_r, s1_valid_nxt;
  logic [1:0]                   s1_mode_r;
  logic [3:0]                   s1_opcode_r;
  logic                         s1_imm_r;
  logic                         s1_setf_r;
  logic [adp_pkg::RegIdxW-1:0]  s1_rn_r;
  logic [adp_pkg::RegIdxW-1:0]  s1_rd_r;
  logic [adp_pkg::Op2W-1:0]     s1_op2_r;
  logic [adp_pkg::DataW-1:0]    s1_load_r;

  logic [2:0]                   flags_r, flags_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [adp_pkg::DataW-1:0]    out_value_r;
  logic                         out_wrote_r;
  logic [adp_pkg::RegIdxW-1:0]  out_wreg_r;
  logic [2:0]                   out_flags_r;
  logic                         out_unsup_r;

  adp_pkg::rf_rd_t              rf_rd;
  adp_pkg::rf_wr_t              rf_wr;
  logic [adp_pkg::DataW-1:0]    rn_data, rm_data, rs_data;
  adp_pkg::shift_res_t          sh_res;
  adp_pkg::alu_res_t            alu_res;

  logic [adp_pkg::DataW-1:0]    res_value;
  logic                         res_wrote;
  logic [adp_pkg::RegIdxW-1:0]  res_wreg;
  logic                         res_unsup;
  logic                         wr_req;
  logic [adp_pkg::RegIdxW-1:0]  wr_addr;
  logic [adp_pkg::DataW-1:0]    wr_data;

  // handshakes
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  // register file reads issued at acceptance
  assign rf_rd.en = in_fire;
  assign rf_rd.rn = in_ch.first_reg;
  assign rf_rd.rm = in_ch.op2_field[3:0];
  assign rf_rd.rs = in_ch.op2_field[11:8];

  assign rf_wr.en   = s1_adv && wr_req;
  assign rf_wr.addr = wr_addr;
  assign rf_wr.data = wr_data;

  adp_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_i      (rf_rd),
    .wr_i      (rf_wr),
    .rn_data_o (rn_data),
    .rm_data_o (rm_data),
    .rs_data_o (rs_data)
  );

  adp_shift u_shift (
    .imm_flag_i (s1_imm_r),
    .op2_i      (s1_op2_r),
    .rm_i       (rm_data),
    .rs_lo_i    (rs_data[7:0]),
    .cin_i      (flags_r[adp_pkg::FlagC]),
    .res_o      (sh_res)
  );

  adp_alu u_alu (
    .opcode_i (s1_opcode_r),
    .a_i      (rn_data),
    .sh_i     (sh_res),
    .res_o    (alu_res)
  );

  // result, write-back and next flags per mode
  always_comb begin
    res_value = '0;
    res_wrote = 1'b0;
    res_wreg  = '0;
    res_unsup = 1'b0;
    flags_nxt = flags_r;
    wr_req    = 1'b0;
    wr_addr   = s1_rd_r;
    wr_data   = alu_res.value;
    case (s1_mode_r)
      adp_pkg::MODE_LOAD: begin
        wr_req    = 1'b1;
        wr_addr   = s1_rn_r;
        wr_data   = s1_load_r;
        res_value = s1_load_r;
        res_wrote = 1'b1;
        res_wreg  = s1_rn_r;
      end
      adp_pkg::MODE_READ: begin
        res_value = rn_data;
      end
      adp_pkg::MODE_EXEC: begin
        if (!alu_res.ok) begin
          res_unsup = 1'b1;
        end else begin
          res_value = alu_res.value;
          if (s1_setf_r) begin
            flags_nxt = {alu_res.value[31], (alu_res.value == '0), alu_res.carry};
          end
          if (alu_res.wr) begin
            wr_req    = 1'b1;
            res_wrote = 1'b1;
            res_wreg  = s1_rd_r;
          end
        end
      end
      default: begin
        res_unsup = 1'b1;
      end
    endcase
  end

  // stage valids
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        flags_r <= flags_nxt;
      end
    end
  end

  // item payload into execute stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r   <= in_ch.mode;
      s1_opcode_r <= in_ch.opcode;
      s1_imm_r    <= in_ch.imm_flag;
      s1_setf_r   <= in_ch.set_flags;
      s1_rn_r     <= in_ch.first_reg;
      s1_rd_r     <= in_ch.dest_reg;
      s1_op2_r    <= in_ch.op2_field;
      s1_load_r   <= in_ch.load_value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value_r <= res_value;
      out_wrote_r <= res_wrote;
      out_wreg_r  <= res_wreg;
      out_flags_r <= flags_nxt;
      out_unsup_r <= res_unsup;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value       = out_value_r;
  assign out_ch.wrote       = out_wrote_r;
  assign out_ch.written_reg = out_wreg_r;
  assign out_ch.flag_n      = out_flags_r[adp_pkg::FlagN];
  assign out_ch.flag_z      = out_flags_r[adp_pkg::FlagZ];
  assign out_ch.flag_c      = out_flags_r[adp_pkg::FlagC];
  assign out_ch.unsupported = out_unsup_r;

  // checks
  a_no_adv_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !s1_adv)
    else $error("execute stage moved into a stalled output register");

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(flags_r))
    else $error("flags changed without a retiring item");

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_ch.valid && !out_ch.ready))
    else $error("input blocked while the pipeline could move");

  a_unsup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_unsup) |-> (!rf_wr.en && (flags_nxt == flags_r)))
    else $error("unsupported item changed state");

endmodule

`default_nettype wire

### hw/rtl/adp_regfile.sv
`default_nettype none

// 16x32 register file: two synchronous copies (Rn/Rm and Rs read ports),
// per-entry valid bits for the zero reset, and a bypass of the latest write.
module adp_regfile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  adp_pkg::rf_rd_t       rd_i,
  input  adp_pkg::rf_wr_t       wr_i,
  output logic [adp_pkg::DataW-1:0] rn_data_o,
  output logic [adp_pkg::DataW-1:0] rm_data_o,
  output logic [adp_pkg::DataW-1:0] rs_data_o
);

  logic [adp_pkg::DataW-1:0]   mem_a_r [adp_pkg::RegCnt];
  logic [adp_pkg::DataW-1:0]   mem_b_r [adp_pkg::RegCnt];
  logic [adp_pkg::RegCnt-1:0]  valid_r;

  logic [adp_pkg::DataW-1:0]   q_rn_r, q_rm_r, q_rs_r;
  logic [adp_pkg::RegIdxW-1:0] a_rn_r, a_rm_r, a_rs_r;
  logic                        v_rn_r, v_rm_r, v_rs_r;

  logic                        lw_valid_r;
  logic [adp_pkg::RegIdxW-1:0] lw_addr_r;
  logic [adp_pkg::DataW-1:0]   lw_data_r;

  // copy A: Rn and Rm ports
  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_a_r[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      q_rn_r <= mem_a_r[rd_i.rn];
      q_rm_r <= mem_a_r[rd_i.rm];
    end
  end

  // copy B: Rs port
  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_b_r[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      q_rs_r <= mem_b_r[rd_i.rs];
    end
  end

  // entry written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_i.en) begin
      valid_r[wr_i.addr] <= 1'b1;
    end
  end

  // read addresses and valid bits alongside the data
  always_ff @(posedge clk) begin
    if (rd_i.en) begin
      a_rn_r <= rd_i.rn;
      a_rm_r <= rd_i.rm;
      a_rs_r <= rd_i.rs;
      v_rn_r <= valid_r[rd_i.rn];
      v_rm_r <= valid_r[rd_i.rm];
      v_rs_r <= valid_r[rd_i.rs];
    end
  end

  // latest write, covers a read issued at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (wr_i.en) begin
      lw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      lw_addr_r <= wr_i.addr;
      lw_data_r <= wr_i.data;
    end
  end

  // bypass, then memory data, then reset value
  always_comb begin
    if (lw_valid_r && (lw_addr_r == a_rn_r)) begin
      rn_data_o = lw_data_r;
    end else begin
      rn_data_o = v_rn_r ? q_rn_r : '0;
    end
    if (lw_valid_r && (lw_addr_r == a_rm_r)) begin
      rm_data_o = lw_data_r;
    end else begin
      rm_data_o = v_rm_r ? q_rm_r : '0;
    end
    if (lw_valid_r && (lw_addr_r == a_rs_r)) begin
      rs_data_o = lw_data_r;
    end else begin
      rs_data_o = v_rs_r ? q_rs_r : '0;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/adp_shift.sv
`default_nettype none

// operand2: rotated immediate or barrel-shifted Rm, with shifter carry
module adp_shift (
  input  logic                      imm_flag_i,
  input  logic [adp_pkg::Op2W-1:0]  op2_i,
  input  logic [adp_pkg::DataW-1:0] rm_i,
  input  logic [7:0]                rs_lo_i,
  input  logic                      cin_i,
  output adp_pkg::shift_res_t       res_o
);

  logic [4:0]                rot;
  logic [adp_pkg::DataW-1:0] imm_val;
  logic [1:0]                kind;
  logic                      by_reg;
  logic [7:0]                amt;
  logic [4:0]                sh;
  logic                      big;
  logic                      is32;
  logic                      sign;
  logic [adp_pkg::DataW:0]   lsl_w;
  logic [adp_pkg::DataW:0]   lsr_w;
  logic signed [adp_pkg::DataW:0] asr_w;
  logic [adp_pkg::DataW-1:0] ror_v;

  // decode and the raw shift results
  always_comb begin
    rot     = {op2_i[11:8], 1'b0};
    imm_val = adp_pkg::ror32({24'd0, op2_i[7:0]}, rot);
    kind    = op2_i[6:5];
    by_reg  = op2_i[4];
    amt     = by_reg ? rs_lo_i : {3'd0, op2_i[11:7]};
    sh      = amt[4:0];
    big     = |amt[7:5];
    is32    = (amt == 8'd32);
    sign    = rm_i[31];
    lsl_w   = {1'b0, rm_i} << sh;
    lsr_w   = {rm_i, 1'b0} >> sh;
    asr_w   = $signed({rm_i, 1'b0}) >>> sh;
    ror_v   = adp_pkg::ror32(rm_i, sh);
  end

  // pick value and carry per ARM shift rules
  always_comb begin
    res_o.value = rm_i;
    res_o.carry = cin_i;
    if (imm_flag_i) begin
      res_o.value = imm_val;
      res_o.carry = (rot != 5'd0) ? imm_val[31] : cin_i;
    end else if (amt == 8'd0) begin
      if (by_reg || (kind == adp_pkg::SH_LSL)) begin
        res_o.value = rm_i;
        res_o.carry = cin_i;
      end else begin
        case (kind)
          adp_pkg::SH_LSR: begin
            res_o.value = '0;
            res_o.carry = sign;
          end
          adp_pkg::SH_ASR: begin
            res_o.value = {adp_pkg::DataW{sign}};
            res_o.carry = sign;
          end
          default: begin
            // RRX
            res_o.value = {cin_i, rm_i[31:1]};
            res_o.carry = rm_i[0];
          end
        endcase
      end
    end else begin
      case (kind)
        adp_pkg::SH_LSL: begin
          if (big) begin
            res_o.value = '0;
            res_o.carry = is32 & rm_i[0];
          end else begin
            res_o.value = lsl_w[adp_pkg::DataW-1:0];
            res_o.carry = lsl_w[adp_pkg::DataW];
          end
        end
        adp_pkg::SH_LSR: begin
          if (big) begin
            res_o.value = '0;
            res_o.carry = is32 & sign;
          end else begin
            res_o.value = lsr_w[adp_pkg::DataW:1];
            res_o.carry = lsr_w[0];
          end
        end
        adp_pkg::SH_ASR: begin
          if (big) begin
            res_o.value = {adp_pkg::DataW{sign}};
            res_o.carry = sign;
          end else begin
            res_o.value = asr_w[adp_pkg::DataW:1];
            res_o.carry = asr_w[0];
          end
        end
        default: begin
          res_o.value = ror_v;
          res_o.carry = ror_v[31];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/adp_alu.sv
`default_nettype none

// data-processing operation on Rn and operand2
module adp_alu (
  input  logic [3:0]                opcode_i,
  input  logic [adp_pkg::DataW-1:0] a_i,
  input  adp_pkg::shift_res_t       sh_i,
  output adp_pkg::alu_res_t         res_o
);

  logic [adp_pkg::DataW:0] sum;
  logic [adp_pkg::DataW:0] dif_ab;
  logic [adp_pkg::DataW:0] dif_ba;

  always_comb begin
    sum    = {1'b0, a_i} + {1'b0, sh_i.value};
    dif_ab = {1'b0, a_i} - {1'b0, sh_i.value};
    dif_ba = {1'b0, sh_i.value} - {1'b0, a_i};
  end

  // subtract carry is "no borrow"
  always_comb begin
    res_o.value = '0;
    res_o.carry = sh_i.carry;
    res_o.wr    = 1'b1;
    res_o.ok    = 1'b1;
    case (opcode_i)
      adp_pkg::OPC_AND: res_o.value = a_i & sh_i.value;
      adp_pkg::OPC_EOR: res_o.value = a_i ^ sh_i.value;
      adp_pkg::OPC_SUB: begin
        res_o.value = dif_ab[adp_pkg::DataW-1:0];
        res_o.carry = ~dif_ab[adp_pkg::DataW];
      end
      adp_pkg::OPC_RSB: begin
        res_o.value = dif_ba[adp_pkg::DataW-1:0];
        res_o.carry = ~dif_ba[adp_pkg::DataW];
      end
      adp_pkg::OPC_ADD: begin
        res_o.value = sum[adp_pkg::DataW-1:0];
        res_o.carry = sum[adp_pkg::DataW];
      end
      adp_pkg::OPC_TST: begin
        res_o.value = a_i & sh_i.value;
        res_o.wr    = 1'b0;
      end
      adp_pkg::OPC_TEQ: begin
        res_o.value = a_i ^ sh_i.value;
        res_o.wr    = 1'b0;
      end
      adp_pkg::OPC_CMP: begin
        res_o.value = dif_ab[adp_pkg::DataW-1:0];
        res_o.carry = ~dif_ab[adp_pkg::DataW];
        res_o.wr    = 1'b0;
      end
      adp_pkg::OPC_ORR: res_o.value = a_i | sh_i.value;
      adp_pkg::OPC_MOV: res_o.value = sh_i.value;
      default: begin
        res_o.wr = 1'b0;
        res_o.ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire
